@@ sv/sle_pkg.sv @@
// ----------------------------------------------------------------------------
// Sequential list engine package
// Shared sizes, request mode codes and controller states.
// ----------------------------------------------------------------------------
package sle_pkg;

   localparam int CAPACITY = 128;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int LEN_W    = 8;
   localparam int WORD_W   = 32;

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_DELETE = 2'd1,
      MODE_LOCATE = 2'd2,
      MODE_DELMIN = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN,
      ST_MOVE,
      ST_DONE
   } state_type;

endpackage

@@ sv/sle_ram.sv @@
// ----------------------------------------------------------------------------
// Sequential list engine RAM
// Simple dual-port memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sle_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/sequential_list_engine.sv @@
// ----------------------------------------------------------------------------
// Sequential list engine
// Ordered list of signed words with insert, delete, locate and delete-minimum.
// ----------------------------------------------------------------------------
// The list lives in one RAM with a single read port, and every request
// streams the entries it touches through that port at one entry per cycle.
// Insert walks length-position+1 entries, delete the same, locate walks up to
// the first match, and delete-minimum walks the whole list and then makes one
// more read to move the last entry. A finished response waits in an output
// register while the next request is taken.
// ----------------------------------------------------------------------------
module sequential_list_engine (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_mode,
   input  logic [sle_pkg::LEN_W-1:0]           req_position,
   input  logic signed [sle_pkg::WORD_W-1:0]   req_item_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_ok,
   output logic signed [sle_pkg::WORD_W-1:0]   rsp_result_value,
   output logic [sle_pkg::LEN_W-1:0]           rsp_found_position,
   output logic [sle_pkg::LEN_W-1:0]           rsp_list_length
);

   localparam int AW = sle_pkg::ADDR_W;
   localparam int LW = sle_pkg::LEN_W;
   localparam int WW = sle_pkg::WORD_W;

   sle_pkg::state_type state_ff, state_in;
   sle_pkg::mode_type  mode_ff, mode_in;
   logic [LW-1:0] pos_ff, pos_in;
   logic [WW-1:0] val_ff, val_in;
   logic [LW-1:0] len_ff, len_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [LW-1:0] rem_ff, rem_in;
   logic          pend_ff, pend_in;
   logic [AW-1:0] pend_addr_ff, pend_addr_in;
   logic          hit_ff, hit_in;
   logic [WW-1:0] best_ff, best_in;
   logic [AW-1:0] best_at_ff, best_at_in;
   logic          ok_ff, ok_in;
   logic [WW-1:0] res_ff, res_in;
   logic [LW-1:0] found_ff, found_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_ok_ff, rsp_ok_in;
   logic [WW-1:0] rsp_res_ff, rsp_res_in;
   logic [LW-1:0] rsp_found_ff, rsp_found_in;
   logic [LW-1:0] rsp_len_ff, rsp_len_in;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [WW-1:0] mem_wdata;
   logic          mem_re;
   logic [AW-1:0] mem_raddr;
   logic [WW-1:0] mem_rdata;

   sle_ram #(
      .WIDTH (WW),
      .DEPTH (sle_pkg::CAPACITY)
   ) u_list_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sle_pkg::ST_IDLE;
         len_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      pos_ff       <= pos_in;
      val_ff       <= val_in;
      ptr_ff       <= ptr_in;
      rem_ff       <= rem_in;
      pend_addr_ff <= pend_addr_in;
      hit_ff       <= hit_in;
      best_ff      <= best_in;
      best_at_ff   <= best_at_in;
      ok_ff        <= ok_in;
      res_ff       <= res_in;
      found_ff     <= found_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_res_ff   <= rsp_res_in;
      rsp_found_ff <= rsp_found_in;
      rsp_len_ff   <= rsp_len_in;
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      len_in       = len_ff;
      ptr_in       = ptr_ff;
      rem_in       = rem_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      hit_in       = hit_ff;
      best_in      = best_ff;
      best_at_in   = best_at_ff;
      ok_in        = ok_ff;
      res_in       = res_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_ok_in    = rsp_ok_ff;
      rsp_res_in   = rsp_res_ff;
      rsp_found_in = rsp_found_ff;
      rsp_len_in   = rsp_len_ff;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = '0;
      mem_re       = 1'b0;
      mem_raddr    = ptr_ff;

      case (state_ff)
         sle_pkg::ST_IDLE: begin
            if (req_valid) begin
               mode_in  = sle_pkg::mode_type'(req_mode);
               pos_in   = req_position;
               val_in   = req_item_value;
               ok_in    = 1'b0;
               res_in   = '0;
               found_in = '0;
               pend_in  = 1'b0;
               hit_in   = 1'b0;
               state_in = sle_pkg::ST_DONE;
               case (sle_pkg::mode_type'(req_mode))
                  sle_pkg::MODE_INSERT: begin
                     if (req_position != '0
                         && {1'b0, req_position} <= {1'b0, len_ff} + (LW+1)'(1)
                         && len_ff < LW'(sle_pkg::CAPACITY)) begin
                        ptr_in   = AW'(len_ff - LW'(1));
                        rem_in   = len_ff - req_position + LW'(1);
                        state_in = sle_pkg::ST_RUN;
                     end
                  end
                  sle_pkg::MODE_DELETE: begin
                     if (req_position != '0 && req_position <= len_ff) begin
                        ptr_in   = AW'(req_position - LW'(1));
                        rem_in   = len_ff - req_position + LW'(1);
                        state_in = sle_pkg::ST_RUN;
                     end
                  end
                  sle_pkg::MODE_LOCATE: begin
                     ok_in    = 1'b1;
                     ptr_in   = '0;
                     rem_in   = len_ff;
                     state_in = sle_pkg::ST_RUN;
                  end
                  sle_pkg::MODE_DELMIN: begin
                     if (len_ff != '0) begin
                        ptr_in   = '0;
                        rem_in   = len_ff;
                        state_in = sle_pkg::ST_RUN;
                     end
                  end
                  default: begin
                     state_in = sle_pkg::ST_DONE;
                  end
               endcase
            end
         end

         sle_pkg::ST_RUN: begin
            // consume the word read last cycle
            if (pend_ff) begin
               case (mode_ff)
                  sle_pkg::MODE_INSERT: begin
                     mem_we    = 1'b1;
                     mem_waddr = pend_addr_ff + AW'(1);
                     mem_wdata = mem_rdata;
                  end
                  sle_pkg::MODE_DELETE: begin
                     if (pend_addr_ff == AW'(pos_ff - LW'(1))) begin
                        res_in = mem_rdata;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = pend_addr_ff - AW'(1);
                        mem_wdata = mem_rdata;
                     end
                  end
                  sle_pkg::MODE_LOCATE: begin
                     if (!hit_ff && mem_rdata == val_ff) begin
                        hit_in   = 1'b1;
                        found_in = LW'(pend_addr_ff) + LW'(1);
                     end
                  end
                  sle_pkg::MODE_DELMIN: begin
                     if (pend_addr_ff == '0 || $signed(mem_rdata) < $signed(best_ff)) begin
                        best_in    = mem_rdata;
                        best_at_in = pend_addr_ff;
                     end
                  end
                  default: begin
                     best_in = best_ff;
                  end
               endcase
            end

            // issue the next read
            if (rem_ff != '0 && !hit_in) begin
               mem_re       = 1'b1;
               mem_raddr    = ptr_ff;
               pend_in      = 1'b1;
               pend_addr_in = ptr_ff;
               rem_in       = rem_ff - LW'(1);
               ptr_in       = (mode_ff == sle_pkg::MODE_INSERT) ? ptr_ff - AW'(1)
                                                                : ptr_ff + AW'(1);
            end else begin
               pend_in = 1'b0;
               if (hit_in) begin
                  rem_in = '0;
               end
            end

            if (!pend_ff && (rem_ff == '0 || hit_ff)) begin
               case (mode_ff)
                  sle_pkg::MODE_INSERT: begin
                     mem_we    = 1'b1;
                     mem_waddr = AW'(pos_ff - LW'(1));
                     mem_wdata = val_ff;
                     len_in    = len_ff + LW'(1);
                     ok_in     = 1'b1;
                     state_in  = sle_pkg::ST_DONE;
                  end
                  sle_pkg::MODE_DELETE: begin
                     len_in   = len_ff - LW'(1);
                     ok_in    = 1'b1;
                     state_in = sle_pkg::ST_DONE;
                  end
                  sle_pkg::MODE_LOCATE: begin
                     state_in = sle_pkg::ST_DONE;
                  end
                  sle_pkg::MODE_DELMIN: begin
                     mem_re    = 1'b1;
                     mem_raddr = AW'(len_ff - LW'(1));
                     state_in  = sle_pkg::ST_MOVE;
                  end
                  default: begin
                     state_in = sle_pkg::ST_DONE;
                  end
               endcase
            end
         end

         sle_pkg::ST_MOVE: begin
            // move the last entry into the freed slot
            mem_we    = 1'b1;
            mem_waddr = best_at_ff;
            mem_wdata = mem_rdata;
            res_in    = best_ff;
            len_in    = len_ff - LW'(1);
            ok_in     = 1'b1;
            state_in  = sle_pkg::ST_DONE;
         end

         sle_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = ok_ff;
               rsp_res_in   = res_ff;
               rsp_found_in = found_ff;
               rsp_len_in   = len_ff;
               state_in     = sle_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = sle_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_stall          = (state_ff != sle_pkg::ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = rsp_ok_ff;
   assign rsp_result_value   = rsp_res_ff;
   assign rsp_found_position = rsp_found_ff;
   assign rsp_list_length    = rsp_len_ff;

endmodule

@@ tb/tb_sequential_list_engine.sv @@
// ----------------------------------------------------------------------------
// Sequential list engine testbench
// Drives insert, delete, locate and delete-minimum requests through the
// valid/stall handshake with random idling on both sides. A shadow copy of
// the list predicts every response, and each response is checked field by
// field in order. Covers empty and full lists, bad positions, extreme words
// and ties in the minimum.
// ----------------------------------------------------------------------------
module tb_sequential_list_engine;

   typedef struct {
      logic                              ok;
      logic signed [sle_pkg::WORD_W-1:0] value;
      logic [sle_pkg::LEN_W-1:0]         found;
      logic [sle_pkg::LEN_W-1:0]         len;
   } outcome_type;

   class list_shadow_type;
      logic signed [sle_pkg::WORD_W-1:0] words [sle_pkg::CAPACITY];
      int unsigned                       length;
      outcome_type                       pending_outcomes [$];
      int unsigned                       errors;
      int unsigned                       per_mode [4];
      int unsigned                       ok_count;
      int unsigned                       peak;

      function new();
         length = 0;
         errors = 0;
         ok_count = 0;
         peak = 0;
         foreach (per_mode[i]) per_mode[i] = 0;
      endfunction

      function void note_request(sle_pkg::mode_type m, logic [sle_pkg::LEN_W-1:0] pos,
                                 logic signed [sle_pkg::WORD_W-1:0] val);
         outcome_type                       o;
         int                                p;
         int                                k;
         int                                at;
         int                                f;
         logic signed [sle_pkg::WORD_W-1:0] best;
         p = pos;
         o.ok = 1'b0;
         o.value = '0;
         o.found = '0;
         per_mode[m]++;
         case (m)
            sle_pkg::MODE_INSERT: begin
               if (p >= 1 && p <= length + 1 && length < sle_pkg::CAPACITY) begin
                  for (k = length; k >= p; k--) words[k] = words[k-1];
                  words[p-1] = val;
                  length++;
                  o.ok = 1'b1;
               end
            end
            sle_pkg::MODE_DELETE: begin
               if (p >= 1 && p <= length) begin
                  o.value = words[p-1];
                  for (k = p; k < length; k++) words[k-1] = words[k];
                  length--;
                  o.ok = 1'b1;
               end
            end
            sle_pkg::MODE_LOCATE: begin
               o.ok = 1'b1;
               for (k = 0; k < length; k++) begin
                  if (words[k] == val) begin
                     f = k + 1;
                     o.found = f[sle_pkg::LEN_W-1:0];
                     break;
                  end
               end
            end
            default: begin
               if (length > 0) begin
                  best = words[0];
                  at = 0;
                  for (k = 1; k < length; k++) begin
                     if (words[k] < best) begin
                        best = words[k];
                        at = k;
                     end
                  end
                  o.value = best;
                  words[at] = words[length-1];
                  length--;
                  o.ok = 1'b1;
               end
            end
         endcase
         if (o.ok) ok_count++;
         if (length > peak) peak = length;
         o.len = length[sle_pkg::LEN_W-1:0];
         pending_outcomes.push_back(o);
      endfunction

      function void check_response(logic ok, logic signed [sle_pkg::WORD_W-1:0] value,
                                   logic [sle_pkg::LEN_W-1:0] found,
                                   logic [sle_pkg::LEN_W-1:0] len);
         outcome_type o;
         if (pending_outcomes.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
            return;
         end
         o = pending_outcomes.pop_front();
         if (ok !== o.ok) begin
            $error("rsp_ok: expected %0d, got %0d", o.ok, ok);
            errors++;
         end
         if (value !== o.value) begin
            $error("rsp_result_value: expected %0d, got %0d", o.value, value);
            errors++;
         end
         if (found !== o.found) begin
            $error("rsp_found_position: expected %0d, got %0d", o.found, found);
            errors++;
         end
         if (len !== o.len) begin
            $error("rsp_list_length: expected %0d, got %0d", o.len, len);
            errors++;
         end
      endfunction
   endclass

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_stall;
   logic [1:0]                        req_mode;
   logic [sle_pkg::LEN_W-1:0]         req_position;
   logic signed [sle_pkg::WORD_W-1:0] req_item_value;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic                              rsp_ok;
   logic signed [sle_pkg::WORD_W-1:0] rsp_result_value;
   logic [sle_pkg::LEN_W-1:0]         rsp_found_position;
   logic [sle_pkg::LEN_W-1:0]         rsp_list_length;
   bit                                quiet = 1'b0;
   list_shadow_type                   shadow;

   sequential_list_engine i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_position       (req_position),
      .req_item_value     (req_item_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_ok             (rsp_ok),
      .rsp_result_value   (rsp_result_value),
      .rsp_found_position (rsp_found_position),
      .rsp_list_length    (rsp_list_length)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= !reset && !quiet && ($urandom_range(99) < 36);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         shadow.check_response(rsp_ok, rsp_result_value, rsp_found_position,
                               rsp_list_length);
      end
   end

   task automatic issue(sle_pkg::mode_type m, int pos,
                        logic signed [sle_pkg::WORD_W-1:0] val);
      if (!quiet && $urandom_range(99) < 36) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 36);
      end
      req_valid      <= 1'b1;
      req_mode       <= m;
      req_position   <= pos[sle_pkg::LEN_W-1:0];
      req_item_value <= val;
      do @(posedge clock); while (req_stall);
      shadow.note_request(m, pos[sle_pkg::LEN_W-1:0], val);
   endtask

   function automatic logic signed [sle_pkg::WORD_W-1:0] pick_word();
      case ($urandom_range(3))
         0: return $urandom_range(8) - 4;
         1: begin
            case ($urandom_range(3))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return 32'h0;
               default: return 32'hffff_ffff;
            endcase
         end
         default: return $urandom();
      endcase
   endfunction

   task automatic random_request(int ins_w, int del_w, int loc_w);
      int                                r;
      int                                pos;
      logic signed [sle_pkg::WORD_W-1:0] val;
      sle_pkg::mode_type                 m;
      r = $urandom_range(99);
      val = pick_word();
      if (r < ins_w) begin
         m = sle_pkg::MODE_INSERT;
         pos = $urandom_range(shadow.length + 1, 1);
      end else if (r < ins_w + del_w) begin
         m = sle_pkg::MODE_DELETE;
         pos = (shadow.length > 0) ? $urandom_range(shadow.length, 1) : 1;
      end else if (r < ins_w + del_w + loc_w) begin
         m = sle_pkg::MODE_LOCATE;
         pos = $urandom_range(255);
         if (shadow.length > 0 && $urandom_range(1))
            val = shadow.words[$urandom_range(shadow.length - 1)];
      end else begin
         m = sle_pkg::MODE_DELMIN;
         pos = $urandom_range(255);
      end
      // mangle the position now and then
      if ($urandom_range(9) == 0) pos = $urandom_range(255);
      issue(m, pos, val);
   endtask

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_mode       = sle_pkg::MODE_INSERT;
      req_position   = '0;
      req_item_value = '0;
      shadow = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      issue(sle_pkg::MODE_LOCATE, 0, 5);
      issue(sle_pkg::MODE_DELMIN, 0, 0);
      issue(sle_pkg::MODE_DELETE, 1, 0);
      issue(sle_pkg::MODE_INSERT, 0, 7);
      issue(sle_pkg::MODE_INSERT, 2, 7);
      issue(sle_pkg::MODE_INSERT, 1, 32'h7fff_ffff);
      issue(sle_pkg::MODE_INSERT, 2, 32'h8000_0000);
      issue(sle_pkg::MODE_INSERT, 1, -1);
      issue(sle_pkg::MODE_INSERT, 2, 0);
      issue(sle_pkg::MODE_INSERT, 255, 1);
      issue(sle_pkg::MODE_INSERT, 5, 32'h8000_0000);
      issue(sle_pkg::MODE_LOCATE, 0, 32'h8000_0000);
      issue(sle_pkg::MODE_LOCATE, 0, 12345);
      issue(sle_pkg::MODE_DELETE, 6, 0);
      issue(sle_pkg::MODE_DELETE, 0, 0);
      issue(sle_pkg::MODE_DELMIN, 0, 0);
      issue(sle_pkg::MODE_DELETE, 4, 0);
      issue(sle_pkg::MODE_DELETE, 1, 0);
      issue(sle_pkg::MODE_INSERT, 128, 3);
      issue(sle_pkg::MODE_LOCATE, 0, 32'h7fff_ffff);
      issue(sle_pkg::MODE_DELMIN, 0, 0);
      issue(sle_pkg::MODE_DELMIN, 0, 0);
      issue(sle_pkg::MODE_DELMIN, 0, 0);

      repeat (160) random_request(40, 20, 20);

      // fill to capacity with no idling on either side
      quiet = 1'b1;
      while (shadow.length < sle_pkg::CAPACITY)
         issue(sle_pkg::MODE_INSERT, $urandom_range(shadow.length + 1, 1), pick_word());
      issue(sle_pkg::MODE_INSERT, 1, 9);
      issue(sle_pkg::MODE_INSERT, sle_pkg::CAPACITY + 1, 9);
      issue(sle_pkg::MODE_LOCATE, 0, shadow.words[sle_pkg::CAPACITY-1]);
      issue(sle_pkg::MODE_DELETE, sle_pkg::CAPACITY + 1, 0);
      issue(sle_pkg::MODE_DELETE, sle_pkg::CAPACITY, 0);
      issue(sle_pkg::MODE_INSERT, sle_pkg::CAPACITY, 32'h8000_0000);
      issue(sle_pkg::MODE_DELMIN, 0, 0);
      quiet = 1'b0;

      repeat (150) random_request(20, 30, 20);

      req_valid <= 1'b0;
      while (shadow.pending_outcomes.size() != 0) @(posedge clock);
      repeat (sle_pkg::CAPACITY + 10) @(posedge clock);

      $display("Ran %0d requests: %0d insert, %0d delete, %0d locate, %0d delete-min",
               shadow.per_mode[0] + shadow.per_mode[1] + shadow.per_mode[2] +
               shadow.per_mode[3], shadow.per_mode[0], shadow.per_mode[1],
               shadow.per_mode[2], shadow.per_mode[3]);
      $display("%0d succeeded, list reached %0d of %0d entries, %0d field errors",
               shadow.ok_count, shadow.peak, sle_pkg::CAPACITY, shadow.errors);
      if (shadow.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

@@ sequential_list_engine.f @@
sv/sle_pkg.sv
sv/sle_ram.sv
sv/sequential_list_engine.sv
tb/tb_sequential_list_engine.sv
